@@ src/gsbc_pkg.sv @@
// Shared types, constants and helpers for the gyro static bias calibrator.
package gsbc_pkg;

   localparam int SAMPLE_W  = 24;
   localparam int SUM_W     = 40;
   localparam int WIN_W     = 16;
   localparam int CNT_W     = 17;
   localparam int AXES      = 3;
   localparam int AXIS_W    = 2;
   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W    = 6;

   localparam logic [CNT_W-1:0]  SKIP_SAMPLES = CNT_W'(10);
   localparam logic [WIN_W-1:0]  WIN_RESET    = WIN_W'(1024);
   localparam logic [AXIS_W-1:0] LAST_AXIS    = AXIS_W'(AXES - 1);
   localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(DIV_STEPS - 1);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   typedef enum logic [1:0] {
      MODE_SAMPLE = 2'd0,
      MODE_START  = 2'd1,
      MODE_STOP   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear;       // zero count, sums and bias
      logic cfg_load;    // take new window size
      logic cnt_inc;     // count a skipped sample
      logic acc;         // add sample to sums and count it
      logic hold_sample; // capture the request's rates
      logic div_start;   // begin bias division
      logic out_load;    // load the result register
      logic out_corr;    // result is corrected rate (else zero)
      logic use_held;    // correct the captured rates, not the port rates
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic skip;     // still inside the discarded samples
      logic in_win;   // inside the averaging window
      logic at_end;   // window complete, this sample sets the bias
      logic win_zero; // window size is zero
      logic div_done; // last bias written this cycle
   } status_type;

   // Subtract and clamp to the signed sample range
   function automatic sample_type sat_sub(sample_type a, sample_type b);
      logic signed [SAMPLE_W:0] d;
      d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
      if (d[SAMPLE_W] != d[SAMPLE_W-1]) begin
         if (d[SAMPLE_W]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
         end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
         end
      end
      return d[SAMPLE_W-1:0];
   endfunction

endpackage

@@ src/gyro_static_bias_calibrator.sv @@
// Top level of the gyro static bias calibrator: controller plus datapath.
// Usage:
//   Request channel (req_valid / req_stall) carries req_mode and three signed
//   rates in dps times 4096. Mode 0 is a sample, 1 starts calibration, 2 stops
//   it. Every request yields exactly one response on rsp_valid / rsp_stall with
//   rsp_cal_x/y/z and rsp_ready_res. Until the bias is known the rates read zero.
//   A start skips ten samples, sums a window of csr_win_len samples per axis,
//   and the next sample sets the bias and is returned corrected and saturated.
//   csr_win_len is written through csr_valid / csr_ready while idle, with
//   requests stalled meanwhile; a write also stops calibration and clears the bias.
// Throughput:
//   An ordinary request gives its registered response in the cycle after
//   acceptance, and a new request can be taken every cycle while the response
//   register drains. The completion sample goes through a one-bit-per-cycle
//   restoring divider shared by the three axes, and req_stall stays high until
//   its response is loaded.
// Reset and stall:
//   Synchronous reset sets the window length to 1024, clears sums and bias and
//   selects pass-through (ready). A stalled response holds, and req_stall rises
//   when the held response has not been taken.
module gyro_static_bias_calibrator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_mode,
   input  logic signed [gsbc_pkg::SAMPLE_W-1:0] req_rate_x,
   input  logic signed [gsbc_pkg::SAMPLE_W-1:0] req_rate_y,
   input  logic signed [gsbc_pkg::SAMPLE_W-1:0] req_rate_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [gsbc_pkg::SAMPLE_W-1:0] rsp_cal_x,
   output logic signed [gsbc_pkg::SAMPLE_W-1:0] rsp_cal_y,
   output logic signed [gsbc_pkg::SAMPLE_W-1:0] rsp_cal_z,
   output logic                                 rsp_ready_res,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gsbc_pkg::WIN_W-1:0]           csr_win_len
);

   gsbc_pkg::cmd_type    cmd;
   gsbc_pkg::status_type status;

   gsbc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_ready_res (rsp_ready_res),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .cmd           (cmd),
      .status        (status)
   );

   gsbc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .rate_x      (req_rate_x),
      .rate_y      (req_rate_y),
      .rate_z      (req_rate_z),
      .win_len     (csr_win_len),
      .cmd         (cmd),
      .status      (status),
      .cal_x       (rsp_cal_x),
      .cal_y       (rsp_cal_y),
      .cal_z       (rsp_cal_z)
   );

endmodule

@@ src/gsbc_ctrl.sv @@
// Controller state machine: handshakes, calibration state and divide sequencing.
module gsbc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_mode,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_ready_res,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   output gsbc_pkg::cmd_type    cmd,
   input  gsbc_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      bias_ready_ff, bias_ready_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      ready_res_ff, ready_res_in;
   logic      out_free;
   logic      accept;
   gsbc_pkg::mode_type mode;

   assign mode          = gsbc_pkg::mode_type'(req_mode);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   // Hold requests off while a register write is offered
   assign req_stall     = !((state_ff == ST_IDLE) && out_free && !csr_valid);
   assign csr_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ready_res = ready_res_ff;

   // Decode requests and sequence the divide
   always_comb begin
      cmd           = '0;
      state_in      = state_ff;
      bias_ready_in = bias_ready_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ready_res_in  = ready_res_ff;

      if (csr_valid && csr_ready) begin
         cmd.cfg_load  = 1'b1;
         cmd.clear     = 1'b1;
         bias_ready_in = 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (mode)
                     gsbc_pkg::MODE_START: begin
                        cmd.clear     = 1'b1;
                        bias_ready_in = 1'b0;
                        cmd.out_load  = 1'b1;
                        rsp_valid_in  = 1'b1;
                        ready_res_in  = 1'b0;
                     end
                     gsbc_pkg::MODE_STOP: begin
                        cmd.clear     = 1'b1;
                        bias_ready_in = 1'b1;
                        cmd.out_load  = 1'b1;
                        rsp_valid_in  = 1'b1;
                        ready_res_in  = 1'b1;
                     end
                     gsbc_pkg::MODE_SAMPLE: begin
                        cmd.hold_sample = 1'b1;
                        if (bias_ready_ff) begin
                           cmd.out_load = 1'b1;
                           cmd.out_corr = 1'b1;
                           rsp_valid_in = 1'b1;
                           ready_res_in = 1'b1;
                        end else if (status.skip || status.in_win || !status.at_end) begin
                           cmd.cnt_inc  = status.skip;
                           cmd.acc      = status.in_win;
                           cmd.out_load = 1'b1;
                           rsp_valid_in = 1'b1;
                           ready_res_in = 1'b0;
                        end else if (status.win_zero) begin
                           // Empty window: bias stays zero, no divide
                           bias_ready_in = 1'b1;
                           cmd.out_load  = 1'b1;
                           cmd.out_corr  = 1'b1;
                           rsp_valid_in  = 1'b1;
                           ready_res_in  = 1'b1;
                        end else begin
                           cmd.div_start = 1'b1;
                           state_in      = ST_DIVIDE;
                        end
                     end
                     default: begin
                        cmd.out_load = 1'b1;
                        rsp_valid_in = 1'b1;
                        ready_res_in = bias_ready_ff;
                     end
                  endcase
               end
            end
            ST_DIVIDE: begin
               if (status.div_done) begin
                  state_in = ST_FINISH;
               end
            end
            ST_FINISH: begin
               // Emit the completion sample once the result register frees
               if (out_free) begin
                  cmd.out_load  = 1'b1;
                  cmd.out_corr  = 1'b1;
                  cmd.use_held  = 1'b1;
                  bias_ready_in = 1'b1;
                  rsp_valid_in  = 1'b1;
                  ready_res_in  = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         bias_ready_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
         ready_res_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         bias_ready_ff <= bias_ready_in;
         rsp_valid_ff  <= rsp_valid_in;
         ready_res_ff  <= ready_res_in;
      end
   end

endmodule

@@ src/gsbc_dpath.sv @@
// Datapath: sample counter, axis sums, serial bias divider, correction and result rates.
module gsbc_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [gsbc_pkg::SAMPLE_W-1:0] rate_x,
   input  logic signed [gsbc_pkg::SAMPLE_W-1:0] rate_y,
   input  logic signed [gsbc_pkg::SAMPLE_W-1:0] rate_z,
   input  logic        [gsbc_pkg::WIN_W-1:0]    win_len,
   input  gsbc_pkg::cmd_type                  cmd,
   output gsbc_pkg::status_type               status,
   output logic signed [gsbc_pkg::SAMPLE_W-1:0] cal_x,
   output logic signed [gsbc_pkg::SAMPLE_W-1:0] cal_y,
   output logic signed [gsbc_pkg::SAMPLE_W-1:0] cal_z
);

   localparam int SW = gsbc_pkg::SAMPLE_W;
   localparam int MW = gsbc_pkg::SUM_W;
   localparam int WW = gsbc_pkg::WIN_W;
   localparam int CW = gsbc_pkg::CNT_W;
   localparam int AW = gsbc_pkg::AXIS_W;
   localparam int NA = gsbc_pkg::AXES;

   logic [WW-1:0]         win_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         win_pos;
   gsbc_pkg::sum_type     sums_ff [NA];
   gsbc_pkg::sample_type  bias_ff [NA];
   gsbc_pkg::sample_type  held_ff [NA];
   gsbc_pkg::sample_type  cal_ff  [NA];
   gsbc_pkg::sample_type  rate_in [NA];
   gsbc_pkg::sample_type  src     [NA];

   // Divider state
   logic                          div_busy_ff;
   logic [AW-1:0]                 div_axis_ff;
   logic [gsbc_pkg::STEP_W-1:0]   div_step_ff;
   logic [MW-1:0]                 div_quo_ff;
   logic [WW-1:0]                 div_rem_ff;
   logic                          div_neg_ff;
   logic [WW:0]                   rem_sh;
   logic                          rem_ge;
   logic [WW:0]                   rem_diff;
   logic [MW-1:0]                 quo_next;
   logic                          div_last;
   logic [AW-1:0]                 load_axis;
   gsbc_pkg::sum_type             load_sum;
   logic [MW-1:0]                 load_mag;
   logic [SW:0]                   quo_trim;
   logic [SW:0]                   bias_val;

   assign rate_in[0] = rate_x;
   assign rate_in[1] = rate_y;
   assign rate_in[2] = rate_z;

   // Window position status
   assign win_pos         = count_ff - gsbc_pkg::SKIP_SAMPLES;
   assign status.skip     = count_ff < gsbc_pkg::SKIP_SAMPLES;
   assign status.in_win   = !status.skip && (win_pos < {1'b0, win_ff});
   assign status.at_end   = !status.skip && (win_pos == {1'b0, win_ff});
   assign status.win_zero = (win_ff == '0);

   // Restoring divide step on the magnitude, one quotient bit per cycle
   assign rem_sh   = {div_rem_ff, div_quo_ff[MW-1]};
   assign rem_ge   = rem_sh >= {1'b0, win_ff};
   assign rem_diff = rem_sh - {1'b0, win_ff};
   assign quo_next = {div_quo_ff[MW-2:0], rem_ge};
   assign div_last = div_busy_ff && (div_step_ff == gsbc_pkg::LAST_STEP);
   assign status.div_done = div_last && (div_axis_ff == gsbc_pkg::LAST_AXIS);

   assign load_axis = cmd.div_start ? '0 : AW'(div_axis_ff + AW'(1));
   assign load_sum  = sums_ff[load_axis];
   assign load_mag  = load_sum[MW-1] ? MW'(-load_sum) : MW'(load_sum);

   // Quotient magnitude fits the sample range, so trim then apply the sign
   assign quo_trim = quo_next[SW:0];
   assign bias_val = div_neg_ff ? (SW+1)'(-quo_trim) : quo_trim;

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.cnt_inc || cmd.acc) begin
         count_in = CW'(count_ff + CW'(1));
      end
   end

   // Advance counter, window and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= gsbc_pkg::WIN_RESET;
         count_ff <= '0;
         for (int i = 0; i < NA; i++) begin
            sums_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         if (cmd.cfg_load) begin
            win_ff <= win_len;
         end
         for (int i = 0; i < NA; i++) begin
            if (cmd.clear) begin
               sums_ff[i] <= '0;
            end else if (cmd.acc) begin
               sums_ff[i] <= sums_ff[i] + MW'(rate_in[i]);
            end
         end
      end
   end

   // Run the divider over the three axes and write each bias
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_axis_ff <= '0;
         div_step_ff <= '0;
         for (int i = 0; i < NA; i++) begin
            bias_ff[i] <= '0;
         end
      end else if (cmd.clear) begin
         div_busy_ff <= 1'b0;
         for (int i = 0; i < NA; i++) begin
            bias_ff[i] <= '0;
         end
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         div_axis_ff <= '0;
         div_step_ff <= '0;
      end else if (div_busy_ff) begin
         div_step_ff <= div_last ? '0 : gsbc_pkg::STEP_W'(div_step_ff + 1'b1);
         if (div_last) begin
            bias_ff[div_axis_ff] <= bias_val[SW-1:0];
            div_axis_ff          <= load_axis;
            if (status.div_done) begin
               div_busy_ff <= 1'b0;
            end
         end
      end
   end

   // Divider payload
   always_ff @(posedge clock) begin
      if (cmd.div_start || div_last) begin
         div_quo_ff <= load_mag;
         div_rem_ff <= '0;
         div_neg_ff <= load_sum[MW-1];
      end else if (div_busy_ff) begin
         div_quo_ff <= quo_next;
         div_rem_ff <= rem_ge ? rem_diff[WW-1:0] : rem_sh[WW-1:0];
      end
   end

   // Capture rates for the completion sample and load results
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         src[i] = cmd.use_held ? held_ff[i] : rate_in[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         if (cmd.hold_sample) begin
            held_ff[i] <= rate_in[i];
         end
         if (cmd.out_load) begin
            cal_ff[i] <= cmd.out_corr ? gsbc_pkg::sat_sub(src[i], bias_ff[i]) : '0;
         end
      end
   end

   assign cal_x = cal_ff[0];
   assign cal_y = cal_ff[1];
   assign cal_z = cal_ff[2];

endmodule

@@ src/gsbc_checker.sv @@
// Port-level checker for the gyro static bias calibrator, bound to the top level.
module gsbc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [1:0]                           req_mode,
   input logic signed [gsbc_pkg::SAMPLE_W-1:0] req_rate_x,
   input logic signed [gsbc_pkg::SAMPLE_W-1:0] req_rate_y,
   input logic signed [gsbc_pkg::SAMPLE_W-1:0] req_rate_z,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [gsbc_pkg::SAMPLE_W-1:0] rsp_cal_x,
   input logic signed [gsbc_pkg::SAMPLE_W-1:0] rsp_cal_y,
   input logic signed [gsbc_pkg::SAMPLE_W-1:0] rsp_cal_z,
   input logic                                 rsp_ready_res,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [gsbc_pkg::WIN_W-1:0]           csr_win_len
);

   // A stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // While calibrating, corrected rates read zero
   a_zero_unready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready_res |-> (rsp_cal_x == '0) && (rsp_cal_y == '0)
                                      && (rsp_cal_z == '0))
      else $error("nonzero rate before bias is known");

   // A stop request answers next cycle with ready and a zero x rate
   a_stop_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == gsbc_pkg::MODE_STOP)
      |=> rsp_valid && rsp_ready_res && (rsp_cal_x == '0))
      else $error("stop request not answered with ready");

   // A start request answers next cycle with not-ready
   a_start_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_mode == gsbc_pkg::MODE_START)
      |=> rsp_valid && !rsp_ready_res)
      else $error("start request not answered with not-ready");

endmodule

bind gyro_static_bias_calibrator gsbc_checker u_gsbc_checker (.*);

@@ verif/tb_gyro_static_bias_calibrator.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the gyro static bias calibrator.
module tb_gyro_static_bias_calibrator;

   localparam int ITEM_TARGET = 1900;
   localparam int QUIET_LIMIT = 1000;
   localparam int DUE_DEPTH   = 8;
   localparam int SKIP_COUNT  = int'(gsbc_pkg::SKIP_SAMPLES);
   localparam longint CAL_HI  = (longint'(1) <<< (gsbc_pkg::SAMPLE_W - 1)) - 1;
   localparam longint CAL_LO  = -CAL_HI - 1;

   localparam gsbc_pkg::sample_type R_MAX = {1'b0, {(gsbc_pkg::SAMPLE_W-1){1'b1}}};
   localparam gsbc_pkg::sample_type R_MIN = {1'b1, {(gsbc_pkg::SAMPLE_W-1){1'b0}}};

   typedef struct packed {
      gsbc_pkg::sample_type cal_x;
      gsbc_pkg::sample_type cal_y;
      gsbc_pkg::sample_type cal_z;
      logic                 ready_res;
   } cal_result_type;

   localparam cal_result_type CAL_HELD       = '{24'sd0, 24'sd0, 24'sd0, 1'b0};
   localparam cal_result_type CAL_ZERO_READY = '{24'sd0, 24'sd0, 24'sd0, 1'b1};

   typedef enum logic {
      ROW_REQ,
      ROW_WINDOW
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      gsbc_pkg::mode_type   mode;
      gsbc_pkg::sample_type x;
      gsbc_pkg::sample_type y;
      gsbc_pkg::sample_type z;
      logic [15:0]          win;
      logic [7:0]           reps;
      logic                 pinned;
      cal_result_type       want;
   } step_row_type;

   localparam int PLAN_ROWS = 18;

   // Directed walk: pinned rows carry their result, the rest go to the predictor
   step_row_type plan [PLAN_ROWS] = '{
      // pass-through after reset, rates at both ends of the range
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, R_MAX, R_MIN, 24'sd0, 16'd0, 8'd1, 1'b1,
        '{R_MAX, R_MIN, 24'sd0, 1'b1}},
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, R_MIN, R_MAX, -24'sd1, 16'd0, 8'd1, 1'b1,
        '{R_MIN, R_MAX, -24'sd1, 1'b1}},
      // unused mode and commands return zero rates
      '{ROW_REQ, gsbc_pkg::MODE_NONE, -24'sd1, -24'sd1, -24'sd1, 16'd0, 8'd1, 1'b1,
        CAL_ZERO_READY},
      '{ROW_REQ, gsbc_pkg::MODE_START, R_MAX, R_MAX, R_MAX, 16'd0, 8'd1, 1'b1, CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_NONE, R_MIN, R_MIN, R_MIN, 16'd0, 8'd1, 1'b1, CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_STOP, R_MIN, R_MAX, R_MIN, 16'd0, 8'd1, 1'b1,
        CAL_ZERO_READY},
      // zero window: first sample after the skipped ones completes with no bias
      '{ROW_WINDOW, gsbc_pkg::MODE_SAMPLE, 24'sd0, 24'sd0, 24'sd0, 16'd0, 8'd1, 1'b0,
        CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_START, 24'sd0, 24'sd0, 24'sd0, 16'd0, 8'd1, 1'b1, CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, R_MIN, R_MIN, R_MIN, 16'd0, 8'd10, 1'b1, CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, 24'sd123, -24'sd456, 24'sd789, 16'd0, 8'd1, 1'b1,
        '{24'sd123, -24'sd456, 24'sd789, 1'b1}},
      // one-sample window at the range ends: the completion sample saturates
      '{ROW_WINDOW, gsbc_pkg::MODE_SAMPLE, 24'sd0, 24'sd0, 24'sd0, 16'd1, 8'd1, 1'b0,
        CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_START, -24'sd1, 24'sd0, -24'sd1, 16'd0, 8'd1, 1'b1,
        CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, -24'sd1, -24'sd1, -24'sd1, 16'd0, 8'd10, 1'b1,
        CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, R_MAX, R_MIN, 24'sd5, 16'd0, 8'd1, 1'b1, CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, R_MIN, R_MAX, 24'sd5, 16'd0, 8'd1, 1'b1,
        '{R_MIN, R_MAX, 24'sd0, 1'b1}},
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, -24'sd1, 24'sd0, 24'sd5, 16'd0, 8'd1, 1'b0,
        CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_SAMPLE, 24'sd0, 24'sd0, 24'sd0, 16'd0, 8'd1, 1'b0, CAL_HELD},
      '{ROW_REQ, gsbc_pkg::MODE_STOP, 24'sd0, 24'sd0, 24'sd0, 16'd0, 8'd1, 1'b1,
        CAL_ZERO_READY}
   };

   logic                       clock;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_mode    = '0;
   gsbc_pkg::sample_type       req_rate_x  = '0;
   gsbc_pkg::sample_type       req_rate_y  = '0;
   gsbc_pkg::sample_type       req_rate_z  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall   = 1'b0;
   gsbc_pkg::sample_type       rsp_cal_x;
   gsbc_pkg::sample_type       rsp_cal_y;
   gsbc_pkg::sample_type       rsp_cal_z;
   logic                       rsp_ready_res;
   logic                       csr_valid   = 1'b0;
   logic                       csr_ready;
   logic [gsbc_pkg::WIN_W-1:0] csr_win_len = '0;

   // Predictor state
   logic [gsbc_pkg::WIN_W-1:0] win_size;
   int                         seen_count;
   longint                     axis_sum [3];
   longint                     axis_bias [3];
   logic                       bias_known;

   // Results owed, oldest at due_rd
   cal_result_type   due_ring [DUE_DEPTH];
   int               due_wr       = 0;
   int               due_rd       = 0;
   cal_result_type   due;
   int               sent_count   = 0;
   int               error_count  = 0;
   int               quiet_cycles = 0;
   int               stall_left   = 0;
   bit               req_steady   = 1'b0;
   bit               rsp_steady   = 1'b0;

   gyro_static_bias_calibrator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_rate_x      (req_rate_x),
      .req_rate_y      (req_rate_y),
      .req_rate_z      (req_rate_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cal_x       (rsp_cal_x),
      .rsp_cal_y       (rsp_cal_y),
      .rsp_cal_z       (rsp_cal_z),
      .rsp_ready_res   (rsp_ready_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_win_len     (csr_win_len)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Drop sums, bias and count; set the ready flag as given
   function automatic void clear_calibration(logic known);
      int a;
      for (a = 0; a < 3; a++) begin
         axis_sum[a]  = 0;
         axis_bias[a] = 0;
      end
      seen_count = 0;
      bias_known = known;
   endfunction

   // Advance the calibration state by one request and return its corrected rates
   function automatic cal_result_type correct_rates(gsbc_pkg::mode_type mode,
                                                    gsbc_pkg::sample_type rx,
                                                    gsbc_pkg::sample_type ry,
                                                    gsbc_pkg::sample_type rz);
      cal_result_type       res;
      longint               rate [3];
      longint               diff;
      gsbc_pkg::sample_type cal [3];
      int                   a;
      int                   span;
      rate[0] = rx;
      rate[1] = ry;
      rate[2] = rz;
      span = int'(win_size);
      for (a = 0; a < 3; a++) cal[a] = '0;
      case (mode)
         gsbc_pkg::MODE_START: clear_calibration(1'b0);
         gsbc_pkg::MODE_STOP:  clear_calibration(1'b1);
         gsbc_pkg::MODE_SAMPLE: begin
            if (!bias_known) begin
               if (seen_count < SKIP_COUNT) begin
                  seen_count++;
               end else if (seen_count - SKIP_COUNT < span) begin
                  for (a = 0; a < 3; a++) axis_sum[a] += rate[a];
                  seen_count++;
               end else if (seen_count - SKIP_COUNT == span) begin
                  // window full: this sample sets the bias, truncated toward zero
                  for (a = 0; a < 3; a++) begin
                     axis_bias[a] = (span != 0) ? axis_sum[a] / longint'(span) : 0;
                  end
                  bias_known = 1'b1;
               end
            end
            if (bias_known) begin
               for (a = 0; a < 3; a++) begin
                  diff = rate[a] - axis_bias[a];
                  if (diff > CAL_HI) diff = CAL_HI;
                  else if (diff < CAL_LO) diff = CAL_LO;
                  cal[a] = gsbc_pkg::sample_type'(diff);
               end
            end
         end
         default: ;
      endcase
      res.cal_x     = cal[0];
      res.cal_y     = cal[1];
      res.cal_z     = cal[2];
      res.ready_res = bias_known;
      return res;
   endfunction

   // Pick a rate near the run's center, with range ends and full noise mixed in
   function automatic gsbc_pkg::sample_type draw_rate(gsbc_pkg::sample_type center);
      case ($urandom_range(0, 7))
         0:       return R_MAX;
         1:       return R_MIN;
         2:       return gsbc_pkg::sample_type'($urandom);
         default: return center + gsbc_pkg::sample_type'($urandom_range(0, 255))
                         - gsbc_pkg::sample_type'(128);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   // Present one request after a random gap and hold it until accepted
   task automatic send_request(input gsbc_pkg::mode_type mode, input gsbc_pkg::sample_type rx,
                               input gsbc_pkg::sample_type ry, input gsbc_pkg::sample_type rz,
                               input logic pinned, input cal_result_type pin);
      int             gap;
      cal_result_type predicted;
      if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_rate_x <= rx;
      req_rate_y <= ry;
      req_rate_z <= rz;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = correct_rates(mode, rx, ry, rz);
      due_ring[due_wr % DUE_DEPTH] = pinned ? pin : predicted;
      due_wr++;
      sent_count++;
   endtask

   // Drain the block, then write the window size (which also stops calibration)
   task automatic write_window(input logic [gsbc_pkg::WIN_W-1:0] size);
      req_valid <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_valid   <= 1'b1;
      csr_win_len <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      win_size = size;
      clear_calibration(1'b1);
   endtask

   // Stimulus: directed plan, then random calibration runs
   initial begin
      int                         phase;
      int                         runs;
      int                         length;
      int                         i;
      int                         a;
      bit                         broken;
      logic [gsbc_pkg::WIN_W-1:0] size;
      gsbc_pkg::sample_type       center [3];
      gsbc_pkg::sample_type       r [3];
      win_size = gsbc_pkg::WIN_RESET;
      clear_calibration(1'b1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[row]) begin
         if (plan[row].kind == ROW_WINDOW) begin
            write_window(plan[row].win);
         end else begin
            repeat (plan[row].reps) begin
               send_request(plan[row].mode, plan[row].x, plan[row].y, plan[row].z,
                            plan[row].pinned, plan[row].want);
            end
         end
      end

      phase = 0;
      while (sent_count < ITEM_TARGET) begin
         // widest window first, walked only part way; then mostly small ones
         if (phase == 0) begin
            size = '1;
         end else begin
            case ($urandom_range(0, 9))
               0:       size = '0;
               1:       size = gsbc_pkg::WIN_W'(1);
               2:       size = gsbc_pkg::WIN_W'(2);
               3:       size = gsbc_pkg::WIN_W'($urandom_range(25, 200));
               default: size = gsbc_pkg::WIN_W'($urandom_range(3, 24));
            endcase
         end
         write_window(size);
         runs = $urandom_range(1, 3);
         repeat (runs) begin
            for (a = 0; a < 3; a++) begin
               case ($urandom_range(0, 3))
                  0:       center[a] = R_MAX;
                  1:       center[a] = R_MIN;
                  2:       center[a] = gsbc_pkg::sample_type'($urandom);
                  default: center[a] = gsbc_pkg::sample_type'($urandom_range(0, 4095))
                                       - gsbc_pkg::sample_type'(2048);
               endcase
            end
            broken = ($urandom_range(0, 4) == 0);
            send_request(gsbc_pkg::MODE_START, gsbc_pkg::sample_type'($urandom),
                         gsbc_pkg::sample_type'($urandom),
                         gsbc_pkg::sample_type'($urandom), 1'b0, '0);
            length = (phase == 0) ? $urandom_range(5, 40) : SKIP_COUNT + int'(size) + 1;
            for (i = 0; i < length; i++) begin
               for (a = 0; a < 3; a++) r[a] = draw_rate(center[a]);
               case ($urandom_range(0, 59))
                  0, 1: send_request(gsbc_pkg::MODE_NONE, r[0], r[1], r[2], 1'b0, '0);
                  2: begin
                     // restart mid-run when the run is broken, else an ordinary sample
                     send_request(broken ? gsbc_pkg::MODE_START : gsbc_pkg::MODE_SAMPLE,
                                  r[0], r[1], r[2], 1'b0, '0);
                  end
                  3: begin
                     if (broken) begin
                        send_request(gsbc_pkg::MODE_STOP, r[0], r[1], r[2], 1'b0, '0);
                        break;
                     end
                     send_request(gsbc_pkg::MODE_SAMPLE, r[0], r[1], r[2], 1'b0, '0);
                  end
                  default: send_request(gsbc_pkg::MODE_SAMPLE, r[0], r[1], r[2], 1'b0, '0);
               endcase
            end
            // further samples, corrected where the run has completed
            repeat ($urandom_range(1, 8)) begin
               for (a = 0; a < 3; a++) r[a] = draw_rate(center[a]);
               send_request(gsbc_pkg::MODE_SAMPLE, r[0], r[1], r[2], 1'b0, '0);
            end
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("gyro_static_bias_calibrator test passed");
      end else begin
         $display("gyro_static_bias_calibrator test failed");
      end
      $finish;
   end

   // Check each accepted response and pace the response stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_wr == due_rd) begin
            report_mismatch("response with no request pending", 1, 0);
         end else begin
            due = due_ring[due_rd % DUE_DEPTH];
            due_rd++;
            if (rsp_cal_x !== due.cal_x) report_mismatch("cal_x", rsp_cal_x, due.cal_x);
            if (rsp_cal_y !== due.cal_y) report_mismatch("cal_y", rsp_cal_y, due.cal_y);
            if (rsp_cal_z !== due.cal_z) report_mismatch("cal_z", rsp_cal_z, due.cal_z);
            if (rsp_ready_res !== due.ready_res) begin
               report_mismatch("ready_res", rsp_ready_res, due.ready_res);
            end
         end
         if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
         stall_left = rsp_steady ? 0 : $urandom_range(0, 6);
         rsp_stall <= (stall_left != 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   // End the run when no channel has moved for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("gyro_static_bias_calibrator test failed");
         $finish;
      end
   end

endmodule
